// File: hw/rtl/hvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_pkg: shared constants and types for the haversine distance pipeline
// Fixed-point formats, CORDIC arctangent table, divider and scaling constants.
// ----------------------------------------------------------------------------
package hvd_pkg;

  // Field widths and bus packing
  localparam int LAT_W       = 30;
  localparam int LON_W       = 31;
  localparam int DIST_W      = 23;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 24;
  localparam int LAT_A_LSB   = 0;
  localparam int LON_A_LSB   = LAT_W;
  localparam int LAT_B_LSB   = LAT_W + LON_W;
  localparam int LON_B_LSB   = 2 * LAT_W + LON_W;

  localparam int ANGLE_FRAC_BITS = 22;
  localparam int DIST_FRAC_BITS  = 8;

  // Q30 datapath with two guard bits; phases are 32-bit turns.
  localparam int Q_FRAC       = 30;
  localparam int PHASE_W      = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CVAL_W       = 34;
  typedef logic signed [CVAL_W-1:0] cval_t;

  localparam cval_t Q30_ONE   = cval_t'(longint'(1) << Q_FRAC);
  localparam cval_t HALF_TURN = cval_t'(longint'(1) << (PHASE_W - 1));
  localparam cval_t GAIN_Q30  = cval_t'(longint'(652032874));

  localparam cval_t ATAN_TAB [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81,
    34'sd41,        34'sd20,        34'sd10,        34'sd5,
    34'sd3,         34'sd1
  };

  // Degrees to phase: the divide by 360 or 720 reduces to a divide by 45
  // after the power-of-two part is folded into the shift.
  localparam int DIV_BASE = 45;
  localparam int HALF_SH  = 28 - ANGLE_FRAC_BITS;
  localparam int FULL_SH  = 29 - ANGLE_FRAC_BITS;
  localparam int NUM_BIAS = 22;
  localparam int NUM_W    = 60 - ANGLE_FRAC_BITS;
  localparam int LO_W     = 19;
  localparam int HI_W     = NUM_W - LO_W;
  localparam int REM_W    = 6;
  localparam int DIV_IN_W = REM_W + LO_W;
  localparam int DIV_M_W  = 26;
  localparam int DIV45_SH = 31;
  localparam longint unsigned DIV45_M =
    ((64'd1 << DIV45_SH) + DIV_BASE - 1) / DIV_BASE;

  // Square root and distance scaling
  localparam int SQRT_BITS = 31;
  localparam int SQ_N_W    = SQRT_BITS + Q_FRAC;
  localparam int ANG_W     = 33;
  localparam int PROD_W    = 64;
  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned RADIUS_KM = 64'd6371;
  localparam longint unsigned KDIST     = (RADIUS_KM * PI_Q30 + 64'd32768) >> 16;
  localparam longint unsigned DIST_MAX  = (64'd1 << DIST_W) - 64'd1;

  // Pipeline depth: phase (5), sin/cos, products and clamp (4), root, atan2, scale (2)
  localparam int SC_LAT  = CORDIC_STEPS + 2;
  localparam int LATENCY = 5 + SC_LAT + 4 + SQRT_BITS + CORDIC_STEPS + 2;

endpackage

// File: hw/rtl/hvd_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_sincos: pipelined rotation CORDIC
// Folds the phase into the right half plane, runs one rotation per stage and
// registers the sine and cosine in Q30.
// ----------------------------------------------------------------------------
module hvd_sincos (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [hvd_pkg::PHASE_W-1:0]  phase_i,
  output hvd_pkg::cval_t               sin_o,
  output hvd_pkg::cval_t               cos_o
);
  import hvd_pkg::*;

  cval_t z_in;
  cval_t z_fold;
  logic  fold;
  cval_t x_q   [0:CORDIC_STEPS];
  cval_t y_q   [0:CORDIC_STEPS];
  cval_t z_q   [0:CORDIC_STEPS-1];
  logic  neg_q [0:CORDIC_STEPS];
  cval_t sin_q;
  cval_t cos_q;

  // Angles beyond a quarter turn are rotated by a half turn and negated later.
  always_comb begin
    z_in   = cval_t'(signed'(phase_i));
    z_fold = z_in;
    fold   = 1'b0;
    if (z_in > Q30_ONE) begin
      z_fold = z_in - HALF_TURN;
      fold   = 1'b1;
    end else if (z_in < -Q30_ONE) begin
      z_fold = z_in + HALF_TURN;
      fold   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= GAIN_Q30;
      y_q[0]   <= '0;
      z_q[0]   <= z_fold;
      neg_q[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic pos;
    assign pos = ~z_q[i][CVAL_W-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]   <= pos ? x_q[i] - (y_q[i] >>> i) : x_q[i] + (y_q[i] >>> i);
        y_q[i+1]   <= pos ? y_q[i] + (x_q[i] >>> i) : y_q[i] - (x_q[i] >>> i);
        neg_q[i+1] <= neg_q[i];
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i+1] <= pos ? z_q[i] - ATAN_TAB[i] : z_q[i] + ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= neg_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
      cos_q <= neg_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: hw/rtl/haversine_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance between two points
// Haversine formula in fixed point: phases, CORDIC sin/cos, Q30 products,
// bitwise square roots, vectoring CORDIC atan2 and scaling by the radius.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload (lowest bit first)
//  s_axis    in         lat_a[29:0], lon_a[60:30], lat_b[90:61], lon_b[121:91]
//  m_axis    out        distance[22:0]
//
//  One request enters per cycle while the output is not stalled; the pipeline
//  depth is set by the two 30-stage CORDIC chains and the 31-stage root.
//  Reset clears only the valid bits of the stages.
//  When the output register holds a result that is not taken, every stage
//  holds and s_axis_tready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module haversine_distance (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // lat_a, lon_a, lat_b, lon_b, zero pad
  input  logic [hvd_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // distance, zero pad
  output logic [hvd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import hvd_pkg::*;

  localparam int NL     = 4;
  localparam int L_DLAT = 0;
  localparam int L_DLON = 1;
  localparam int L_LATA = 2;
  localparam int L_LATB = 3;

  // Floor division by 45 for values below 2^25 by reciprocal multiply.
  function automatic logic [DIV_IN_W-1:0] div45(input logic [DIV_IN_W-1:0] x);
    logic [DIV_IN_W+DIV_M_W-1:0] p;
    p = (DIV_IN_W+DIV_M_W)'(x) * (DIV_IN_W+DIV_M_W)'(DIV45_M);
    return DIV_IN_W'(p >> DIV45_SH);
  endfunction

  // Q30 product of magnitudes, rounded half up.
  function automatic logic [31:0] mulq30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'((p + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC);
  endfunction

  // ---------------- handshake and valid chain ----------------
  logic               adv;
  logic [LATENCY-1:0] v_q;

  assign adv = ~v_q[LATENCY-1] | m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LATENCY-2:0], s_axis_tvalid_i};
    end
  end

  // ---------------- degrees to phase ----------------
  logic signed [LAT_W-1:0] lat_a, lat_b;
  logic signed [LON_W-1:0] lon_a, lon_b;
  logic signed [LAT_W:0]   dlat;
  logic signed [LON_W:0]   dlon;
  logic [LAT_W:0]          mag_dlat;
  logic [LON_W:0]          mag_dlon;
  logic [LAT_W-1:0]        mag_lata, mag_latb;

  logic [NUM_W-1:0]    num_d [NL];
  logic [NUM_W-1:0]    num_q [NL];
  logic [NL-1:0]       sgn_d, sgn1_q, sgn2_q, sgn3_q, sgn4_q;
  logic [HI_W-1:0]     qh_d  [NL];
  logic [HI_W-1:0]     qh_q  [NL];
  logic [HI_W-1:0]     hi_q  [NL];
  logic [HI_W-1:0]     qh3_q [NL];
  logic [HI_W-1:0]     p45   [NL];
  logic [LO_W-1:0]     lo_q  [NL];
  logic [DIV_IN_W-1:0] xl_d  [NL];
  logic [DIV_IN_W-1:0] xl_q  [NL];
  logic [PHASE_W-1:0]  qt_d  [NL];
  logic [PHASE_W-1:0]  qt_q  [NL];
  logic [PHASE_W-1:0]  phase_q [NL];

  always_comb begin
    lat_a = s_axis_tdata_i[LAT_A_LSB +: LAT_W];
    lon_a = s_axis_tdata_i[LON_A_LSB +: LON_W];
    lat_b = s_axis_tdata_i[LAT_B_LSB +: LAT_W];
    lon_b = s_axis_tdata_i[LON_B_LSB +: LON_W];
    dlat  = (LAT_W+1)'(lat_b) - (LAT_W+1)'(lat_a);
    dlon  = (LON_W+1)'(lon_b) - (LON_W+1)'(lon_a);

    mag_dlat = dlat[LAT_W] ? (LAT_W+1)'(-dlat) : (LAT_W+1)'(dlat);
    mag_dlon = dlon[LON_W] ? (LON_W+1)'(-dlon) : (LON_W+1)'(dlon);
    mag_lata = lat_a[LAT_W-1] ? LAT_W'(-lat_a) : LAT_W'(lat_a);
    mag_latb = lat_b[LAT_W-1] ? LAT_W'(-lat_b) : LAT_W'(lat_b);

    // Rounded numerators, already divided by the power-of-two part of 360 or 720.
    num_d[L_DLAT] = (NUM_W'(mag_dlat) << HALF_SH) + NUM_W'(NUM_BIAS);
    num_d[L_DLON] = (NUM_W'(mag_dlon) << HALF_SH) + NUM_W'(NUM_BIAS);
    num_d[L_LATA] = (NUM_W'(mag_lata) << FULL_SH) + NUM_W'(NUM_BIAS);
    num_d[L_LATB] = (NUM_W'(mag_latb) << FULL_SH) + NUM_W'(NUM_BIAS);

    sgn_d[L_DLAT] = dlat[LAT_W];
    sgn_d[L_DLON] = dlon[LON_W];
    sgn_d[L_LATA] = lat_a[LAT_W-1];
    sgn_d[L_LATB] = lat_b[LAT_W-1];

    // Long division by 45 in two digits: high digit, then remainder with low digit.
    for (int l = 0; l < NL; l++) begin
      qh_d[l] = HI_W'(div45(DIV_IN_W'(num_q[l][NUM_W-1:LO_W])));
      p45[l]  = qh_q[l] * HI_W'(DIV_BASE);
      xl_d[l] = {REM_W'(hi_q[l] - p45[l]), lo_q[l]};
      qt_d[l] = PHASE_W'({qh3_q[l], LO_W'(div45(xl_q[l]))});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sgn1_q <= sgn_d;
      sgn2_q <= sgn1_q;
      sgn3_q <= sgn2_q;
      sgn4_q <= sgn3_q;
      for (int l = 0; l < NL; l++) begin
        num_q[l]   <= num_d[l];
        qh_q[l]    <= qh_d[l];
        hi_q[l]    <= num_q[l][NUM_W-1:LO_W];
        lo_q[l]    <= num_q[l][LO_W-1:0];
        xl_q[l]    <= xl_d[l];
        qh3_q[l]   <= qh_q[l];
        qt_q[l]    <= qt_d[l];
        phase_q[l] <= sgn4_q[l] ? -qt_q[l] : qt_q[l];
      end
    end
  end

  // ---------------- sine and cosine ----------------
  cval_t s1, s2, c1, c2;

  hvd_sincos u_sc_dlat (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (phase_q[L_DLAT]),
    .sin_o   (s1),
    .cos_o   ()
  );

  hvd_sincos u_sc_dlon (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (phase_q[L_DLON]),
    .sin_o   (s2),
    .cos_o   ()
  );

  hvd_sincos u_sc_lata (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (phase_q[L_LATA]),
    .sin_o   (),
    .cos_o   (c1)
  );

  hvd_sincos u_sc_latb (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (phase_q[L_LATB]),
    .sin_o   (),
    .cos_o   (c2)
  );

  // ---------------- haversine term a ----------------
  logic [31:0]           mag_q [NL];
  logic                  cc_neg_q, cc_neg2_q, cc_neg3_q;
  logic [31:0]           hlat_q, hlon_q, ccm_q, hlat3_q, ccr_q;
  cval_t                 a_sum;
  logic [SQRT_BITS-1:0]  a_cl, b_cl;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q[0]  <= 32'(s1[CVAL_W-1] ? -s1 : s1);
      mag_q[1]  <= 32'(s2[CVAL_W-1] ? -s2 : s2);
      mag_q[2]  <= 32'(c1[CVAL_W-1] ? -c1 : c1);
      mag_q[3]  <= 32'(c2[CVAL_W-1] ? -c2 : c2);
      cc_neg_q  <= c1[CVAL_W-1] ^ c2[CVAL_W-1];

      hlat_q    <= mulq30(mag_q[0], mag_q[0]);
      hlon_q    <= mulq30(mag_q[1], mag_q[1]);
      ccm_q     <= mulq30(mag_q[2], mag_q[3]);
      cc_neg2_q <= cc_neg_q;

      hlat3_q   <= hlat_q;
      ccr_q     <= mulq30(ccm_q, hlon_q);
      cc_neg3_q <= cc_neg2_q;
    end
  end

  // A latitude beyond a pole can push a outside [0, 1]; it is clamped there.
  always_comb begin
    a_sum = cc_neg3_q ? cval_t'(CVAL_W'(hlat3_q)) - cval_t'(CVAL_W'(ccr_q))
                      : cval_t'(CVAL_W'(hlat3_q)) + cval_t'(CVAL_W'(ccr_q));
    if (a_sum[CVAL_W-1]) begin
      a_cl = '0;
    end else if (a_sum > Q30_ONE) begin
      a_cl = SQRT_BITS'(Q30_ONE);
    end else begin
      a_cl = SQRT_BITS'(a_sum);
    end
    b_cl = SQRT_BITS'(Q30_ONE) - a_cl;
  end

  // ---------------- square roots, one result bit per stage ----------------
  logic [SQ_N_W-1:0]    sq_rem_q  [2][SQRT_BITS];
  logic [SQRT_BITS-1:0] sq_root_q [2][SQRT_BITS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q[0][0]  <= SQ_N_W'(a_cl) << Q_FRAC;
      sq_rem_q[1][0]  <= SQ_N_W'(b_cl) << Q_FRAC;
      sq_root_q[0][0] <= '0;
      sq_root_q[1][0] <= '0;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_sq_lane
    for (genvar s = 1; s <= SQRT_BITS; s++) begin : g_sq_stage
      localparam int BIT = SQRT_BITS - s;
      logic [SQ_N_W-1:0] trial;
      logic              fit;

      assign trial = (SQ_N_W'(sq_root_q[l][s-1]) << (BIT + 1))
                   + (SQ_N_W'(1) << (2 * BIT));
      assign fit   = sq_rem_q[l][s-1] >= trial;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          sq_root_q[l][s] <= fit ? (sq_root_q[l][s-1] | (SQRT_BITS'(1) << BIT))
                                 : sq_root_q[l][s-1];
        end
      end

      if (s < SQRT_BITS) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (adv) begin
            sq_rem_q[l][s] <= fit ? sq_rem_q[l][s-1] - trial : sq_rem_q[l][s-1];
          end
        end
      end
    end
  end

  // ---------------- atan2(sqrt(a), sqrt(1-a)) by vectoring ----------------
  cval_t vx_q [1:CORDIC_STEPS-1];
  cval_t vy_q [1:CORDIC_STEPS-1];
  cval_t vz_q [1:CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    cval_t cx, cy, cz;
    logic  up;

    if (k == 0) begin : g_first
      assign cx = cval_t'(CVAL_W'(sq_root_q[1][SQRT_BITS]));
      assign cy = cval_t'(CVAL_W'(sq_root_q[0][SQRT_BITS]));
      assign cz = '0;
    end else begin : g_next
      assign cx = vx_q[k];
      assign cy = vy_q[k];
      assign cz = vz_q[k];
    end

    assign up = ~cy[CVAL_W-1] & (cy != '0);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        vz_q[k+1] <= up ? cz + ATAN_TAB[k] : cz - ATAN_TAB[k];
      end
    end

    if (k < CORDIC_STEPS - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (adv) begin
          vx_q[k+1] <= up ? cx + (cy >>> k) : cx - (cy >>> k);
          vy_q[k+1] <= up ? cy - (cx >>> k) : cy + (cx >>> k);
        end
      end
    end
  end

  // ---------------- scale by the radius and saturate ----------------
  cval_t              zf;
  logic [ANG_W-1:0]   ang;
  logic [PROD_W-1:0]  dprod_q;
  logic [PROD_W-1:0]  dsum, dsh;
  logic [DIST_W-1:0]  dist_q;

  always_comb begin
    zf   = vz_q[CORDIC_STEPS];
    // CORDIC error can leave a zero angle slightly negative.
    ang  = zf[CVAL_W-1] ? '0 : ANG_W'(zf);
    dsum = dprod_q + (PROD_W'(1) << (44 - DIST_FRAC_BITS));
    dsh  = dsum >> (45 - DIST_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dprod_q <= PROD_W'({ang, 1'b0}) * PROD_W'(KDIST);
      dist_q  <= (dsh > PROD_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(dsh);
    end
  end

  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = v_q[LATENCY-1];
  assign m_axis_tdata_o  = OUT_TDATA_W'(dist_q);

endmodule

// File: tb/sv/haversine_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_tb: self-checking bench for the haversine distance block
// Drives point pairs on the input stream, predicts each distance with a
// bit-exact fixed-point model and compares every output request in order.
// ----------------------------------------------------------------------------
module haversine_distance_tb;
  import hvd_pkg::*;

  localparam int PIPE_DEPTH = 104;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint DEG = 64'sd4194304;
  localparam int DIR_ROWS = 16;

  typedef struct {
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;
    logic                    has_dist;
    logic [DIST_W-1:0]       exp_dist;
  } pair_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  haversine_distance u_top (.*);

  logic [DIST_W-1:0] dist_queue[$];
  int     err_count;
  longint cycles;
  int     send_idle, recv_idle;
  int     hold_cycles;
  pair_t  dir_tab[DIR_ROWS];

  const longint atan_q30[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Degrees scaled by 2^22 to a 32-bit phase; div is 360 or 720.
  function automatic longint deg_to_phase(input longint v, input longint div);
    longint mag, q;
    mag = (v < 0) ? -v : v;
    q = ((mag << 10) + div / 2) / div;
    if (v < 0) q = -q;
    return q & 64'hFFFF_FFFF;
  endfunction

  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic void rot_sincos(input longint ph, output longint s,
                                     output longint c);
    longint z, x, y, t;
    bit flip;
    z = ph;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31);
      flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31);
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= atan_q30[i];
      end else begin
        t = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += atan_q30[i];
      end
      x = t;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    longint unsigned ma, mb, r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r = (ma * mb + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint atan2_phase(input longint x, input longint y);
    longint z, t;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      if (y > 0) begin
        t = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += atan_q30[i];
      end else begin
        t = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= atan_q30[i];
      end
      x = t;
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic logic [DIST_W-1:0] great_circle(input pair_t p);
    longint la, oa, lb, ob, s1, s2, c1, c2, junk, a, b, ang;
    longint unsigned kd, d;
    la = longint'(p.lat_a); oa = longint'(p.lon_a);
    lb = longint'(p.lat_b); ob = longint'(p.lon_b);
    rot_sincos(deg_to_phase(lb - la, 720), s1, junk);
    rot_sincos(deg_to_phase(ob - oa, 720), s2, junk);
    rot_sincos(deg_to_phase(la, 360), junk, c1);
    rot_sincos(deg_to_phase(lb, 360), junk, c2);
    a = q30_mul(s1, s1) + q30_mul(q30_mul(c1, c2), q30_mul(s2, s2));
    // Latitudes beyond the poles can push a out of [0,1].
    if (a < 0) a = 0;
    if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
    b = (64'sd1 <<< 30) - a;
    ang = atan2_phase(longint'(int_sqrt(longint'(b) << 30)),
                      longint'(int_sqrt(longint'(a) << 30)));
    kd = (64'd6371 * 64'd3373259426 + 64'd32768) >> 16;
    d = (longint'(2 * ang) * kd + (64'd1 << 36)) >> 37;
    if (d > 64'd8388607) d = 64'd8388607;
    return d[DIST_W-1:0];
  endfunction

  function automatic pair_t mk(input longint la, input longint oa, input longint lb,
                               input longint ob, input bit has, input longint dv);
    pair_t p;
    p.lat_a = LAT_W'(la); p.lon_a = LON_W'(oa);
    p.lat_b = LAT_W'(lb); p.lon_b = LON_W'(ob);
    p.has_dist = has;
    p.exp_dist = DIST_W'(dv);
    return p;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p.has_dist = 0;
    p.exp_dist = '0;
    if (mode == 0) begin
      // Raw bit patterns: out-of-range coordinates wrap as angles.
      p.lat_a = LAT_W'($urandom); p.lon_a = LON_W'($urandom);
      p.lat_b = LAT_W'($urandom); p.lon_b = LON_W'($urandom);
    end else begin
      p.lat_a = LAT_W'(longint'($urandom_range(0, 755000000)) - 377487360);
      p.lon_a = LON_W'(longint'($urandom_range(0, 1509949440)) - 754974720);
      if (mode <= 2) begin
        // Nearby points, the usual case for short hops.
        p.lat_b = LAT_W'(longint'(p.lat_a) + longint'($urandom_range(0, 200000))
                         - 100000);
        p.lon_b = LON_W'(longint'(p.lon_a) + longint'($urandom_range(0, 200000))
                         - 100000);
      end else begin
        p.lat_b = LAT_W'(longint'($urandom_range(0, 755000000)) - 377487360);
        p.lon_b = LON_W'(longint'($urandom_range(0, 1509949440)) - 754974720);
      end
    end
    return p;
  endfunction

  task automatic send(input pair_t p);
    logic [DIST_W-1:0] want;
    logic [IN_TDATA_W-1:0] word;
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    word = '0;
    word[LAT_A_LSB +: LAT_W] = p.lat_a;
    word[LON_A_LSB +: LON_W] = p.lon_a;
    word[LAT_B_LSB +: LAT_W] = p.lat_b;
    word[LON_B_LSB +: LON_W] = p.lon_b;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = great_circle(p);
    if (p.has_dist && want != p.exp_dist)
      report("predictor vs typed value", longint'(want), longint'(p.exp_dist));
    dist_queue = {dist_queue, (p.has_dist ? p.exp_dist : want)};
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (m_axis_tdata_o[OUT_TDATA_W-1:DIST_W] != '0)
        report("tdata pad", longint'(m_axis_tdata_o), 0);
      if (dist_queue.size() == 0) begin
        report("distance with none pending", longint'(m_axis_tdata_o[DIST_W-1:0]), -1);
      end else begin
        if (m_axis_tdata_o[DIST_W-1:0] != dist_queue[0])
          report("distance", longint'(m_axis_tdata_o[DIST_W-1:0]),
                 longint'(dist_queue[0]));
        void'(dist_queue.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int n;
    cycles = 0;
    err_count = 0;
    hold_cycles = 0;
    send_idle = 16;
    recv_idle = 49;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Same point, poles, antipodes, date line and wrap cases.
    dir_tab = '{
      mk(0, 0, 0, 0, 1, 0),
      mk(45*DEG, 90*DEG, 45*DEG, 90*DEG, 1, 0),
      mk(90*DEG, 0, -90*DEG, 0, 0, 0),
      mk(0, 0, 0, 180*DEG, 0, 0),
      mk(0, -180*DEG, 0, 180*DEG, 0, 0),
      mk(-90*DEG, -180*DEG, 90*DEG, 180*DEG, 0, 0),
      mk(0, 0, 0, 1, 0, 0),
      mk(0, 0, 1, 0, 0, 0),
      mk(0, 179*DEG, 0, -179*DEG, 0, 0),
      mk(60*DEG, 10*DEG, 60*DEG, 100*DEG, 0, 0),
      mk(536870911, 1073741823, -536870912, -1073741824, 0, 0),
      mk(-536870912, -1073741824, 536870911, 1073741823, 0, 0),
      mk(100*DEG, 0, 100*DEG, 30*DEG, 0, 0),
      mk(-1, -1, -1, -1, 1, 0),
      mk(0, 0, 0, 360*DEG, 0, 0),
      mk(89*DEG, 0, 89*DEG, 180*DEG, 0, 0)
    };
    foreach (dir_tab[i]) send(dir_tab[i]);

    for (n = 0; n < 900; n++) begin
      if (n == 300) begin
        send_idle = 49;
        recv_idle = 16;
      end
      if (n == 450) hold_cycles = 300;
      if (n == 600) begin
        send_idle = 0;
        recv_idle = 0;
      end
      send(rand_pair());
    end
    s_axis_tvalid_i <= 1'b0;
    while (dist_queue.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
